FILE: hw/rtl/kiht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kiht_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int SLOTS_DEF    = 512;

   localparam int KEY_W   = 64;
   localparam int FLAG_W  = 8;
   localparam int INDEX_W = 8;
   localparam int HALF_W  = 32;

   localparam logic [KEY_W-1:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;

   typedef enum logic [1:0] {
      ST_EXISTING  = 2'd0,
      ST_ADDED     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  key;
      logic [FLAG_W-1:0] new_flags;
   } op_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] entry_index;
      logic [FLAG_W-1:0]  entry_flags;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/kiht_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module kiht_hash #(
   parameter int SLOTS = kiht_pkg::SLOTS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   input  wire logic [kiht_pkg::KEY_W-1:0]                key,
   output logic                                           done,
   output logic [$clog2(SLOTS)-1:0]                       slot
);
   import kiht_pkg::*;

   localparam int SB = $clog2(SLOTS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [1:0]            step_ff, step_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [2*HALF_W-1:0]   prod_ff, prod_in;
   logic [SB-1:0]         acc_ff, acc_in;
   logic [HALF_W-1:0]     a_op;
   logic [HALF_W-1:0]     b_op;

   // The low half of key times constant is built from three 32-bit partial products.
   always_comb begin
      case (step_ff)
         2'd0: begin
            a_op = key_ff[HALF_W-1:0];
            b_op = GOLDEN_MUL[HALF_W-1:0];
         end
         2'd1: begin
            a_op = key_ff[HALF_W-1:0];
            b_op = GOLDEN_MUL[KEY_W-1:HALF_W];
         end
         default: begin
            a_op = key_ff[KEY_W-1:HALF_W];
            b_op = GOLDEN_MUL[HALF_W-1:0];
         end
      endcase
   end

   assign prod_in = (2*HALF_W)'(a_op) * (2*HALF_W)'(b_op);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      key_in  = key_ff;
      acc_in  = acc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = 2'd0;
            key_in  = key;
         end
      end else begin
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff[HALF_W +: SB];
            2'd2: acc_in = acc_ff + prod_ff[SB-1:0];
            default: begin
               acc_in  = acc_ff + prod_ff[SB-1:0];
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign slot = acc_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/kiht_core.sv
`timescale 1ns / 1ps
`default_nettype none

module kiht_core #(
   parameter int CAPACITY = kiht_pkg::CAPACITY_DEF,
   parameter int SLOTS    = kiht_pkg::SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 op_valid,
   input  wire kiht_pkg::op_type     op,
   output logic                      idle,
   output logic                      res_valid,
   output kiht_pkg::result_type      res,
   input  wire logic                 res_ack
);
   import kiht_pkg::*;

   localparam int SB = $clog2(SLOTS);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HASH  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_SLOT  = 7'b0010000,
      S_KEY   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   result_type        res_ff, res_in;
   logic [SB-1:0]     j_ff, j_in;
   logic [SB-1:0]     n_ff, n_in;
   logic [SB-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     slot_rd_ff;
   logic [KEY_W-1:0]  key_rd_ff;
   logic [FLAG_W-1:0] flag_rd_ff;

   logic [CW-1:0]     slot_mem [SLOTS];
   logic [KEY_W-1:0]  key_mem [CAPACITY];
   logic [FLAG_W-1:0] flag_mem [CAPACITY];

   logic              slot_we;
   logic [SB-1:0]     slot_wa;
   logic [CW-1:0]     slot_wd;
   logic              key_we;
   logic              flag_we;
   logic [IW-1:0]     ent_wa;
   logic [FLAG_W-1:0] flag_wd;
   logic [IW-1:0]     ent_ra;

   logic              hash_start;
   logic              hash_done;
   logic [SB-1:0]     hash_slot;

   logic              hit;
   logic              miss;
   logic              have_free;
   logic              advance;
   logic [FLAG_W-1:0] merged;

   assign hash_start = (state_ff == S_IDLE) && op_valid;

   kiht_hash #(
      .SLOTS(SLOTS)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key  (op.key),
      .done (hash_done),
      .slot (hash_slot)
   );

   assign ent_ra = IW'(slot_rd_ff - CW'(1));
   assign merged = op_ff.action ? (flag_rd_ff | op_ff.new_flags) : flag_rd_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      res_in    = res_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      slot_we   = 1'b0;
      slot_wa   = j_ff;
      slot_wd   = '0;
      key_we    = 1'b0;
      flag_we   = 1'b0;
      ent_wa    = IW'(count_ff);
      flag_wd   = op_ff.new_flags;
      hit       = 1'b0;
      miss      = 1'b0;
      have_free = 1'b0;
      advance   = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            clr_in  = clr_ff + SB'(1);
            if (clr_ff == SB'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (op_valid) begin
               op_in    = op;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               j_in     = hash_slot;
               n_in     = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_SLOT;
         end
         S_SLOT: begin
            if (slot_rd_ff == '0) begin
               miss      = 1'b1;
               have_free = 1'b1;
            end else if (slot_rd_ff <= CW'(CAPACITY)) begin
               state_in = S_KEY;
            end else begin
               advance = 1'b1;
            end
         end
         S_KEY: begin
            if (key_rd_ff == op_ff.key) begin
               hit = 1'b1;
            end else begin
               advance = 1'b1;
            end
         end
         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (n_ff == SB'(SLOTS - 1)) begin
            miss = 1'b1;
         end else begin
            n_in     = n_ff + SB'(1);
            j_in     = j_ff + SB'(1);
            state_in = S_READ;
         end
      end

      if (hit) begin
         flag_we  = op_ff.action;
         ent_wa   = ent_ra;
         flag_wd  = merged;
         res_in   = '{status: ST_EXISTING, entry_index: INDEX_W'(ent_ra), entry_flags: merged};
         state_in = S_DONE;
      end

      if (miss) begin
         state_in = S_DONE;
         if (!op_ff.action) begin
            res_in = '{status: ST_NOT_FOUND, entry_index: '0, entry_flags: '0};
         end else if (count_ff >= CW'(CAPACITY) || !have_free) begin
            res_in = '{status: ST_FULL, entry_index: '0, entry_flags: '0};
         end else begin
            key_we   = 1'b1;
            flag_we  = 1'b1;
            slot_we  = 1'b1;
            slot_wa  = j_ff;
            slot_wd  = count_ff + CW'(1);
            count_in = count_ff + CW'(1);
            res_in   = '{status: ST_ADDED, entry_index: INDEX_W'(count_ff),
                         entry_flags: op_ff.new_flags};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
   end

   always_ff @(posedge clock) begin
      slot_rd_ff <= slot_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[ent_wa] <= op_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[ent_ra];
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[ent_wa] <= flag_wd;
      end
   end

   always_ff @(posedge clock) begin
      flag_rd_ff <= flag_mem[ent_ra];
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/key_intern_hash_table_top.sv
// Key interning table: maps 64-bit keys to dense indices in order of first intern.
// An item on the req_ channel carries the action in req_tuser (0 find, 1 intern)
// and the key and new flags in req_tdata. Each item gives exactly one item on the
// rsp_ channel: the status in rsp_tuser, the entry index and flags in rsp_tdata.
// The home slot comes from one 32 by 32 multiplier shared by three partial products; the
// slot table is probed linearly, one slot read and one key read per occupied slot.
// One item is processed at a time; req_tready rises once the result has moved into the
// output register. The output register lets the next item be accepted while a
// result waits, but a second result is held inside the block until rsp_tready
// takes the first. After reset the slot table is swept clear, one slot per cycle,
// through all SLOTS slots (512 by default), and req_tready stays low throughout.
`timescale 1ns / 1ps
`default_nettype none

module key_intern_hash_table_top #(
   parameter int CAPACITY = kiht_pkg::CAPACITY_DEF,
   parameter int SLOTS    = kiht_pkg::SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // key [63:0], new_flags [71:64]
   input  wire logic [0:0]  req_tuser,  // action [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // entry_index [7:0], entry_flags [15:8]
   output logic [1:0]       rsp_tuser   // status [1:0]
);
   import kiht_pkg::*;

   op_type     op;
   logic       core_idle;
   logic       res_valid;
   result_type res;
   logic       res_ack;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign op = '{action: req_tuser[0], key: req_tdata[KEY_W-1:0],
                 new_flags: req_tdata[KEY_W +: FLAG_W]};

   kiht_core #(
      .CAPACITY(CAPACITY),
      .SLOTS   (SLOTS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .op_valid (req_tvalid),
      .op       (op),
      .idle     (core_idle),
      .res_valid(res_valid),
      .res      (res),
      .res_ack  (res_ack)
   );

   assign req_tready = core_idle;
   assign res_ack    = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.entry_flags, rsp_ff.entry_index};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire

FILE: dv/tb_key_intern_hash_table_top.sv
`timescale 1ns / 1ps

module tb_key_intern_hash_table_top;

   localparam int          PHASE_ITEMS    = 345;
   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          SETTLE_CYCLES  = 40;
   localparam logic        ACT_FIND       = 1'b0;
   localparam logic        ACT_INTERN     = 1'b1;
   localparam logic [63:0] KEY_ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   // Shadow copy of the table that predicts the answer to every accepted item.
   class intern_scoreboard;
      logic [63:0]          key_store  [kiht_pkg::CAPACITY_DEF];
      logic [7:0]           flag_store [kiht_pkg::CAPACITY_DEF];
      logic [8:0]           slot_table [kiht_pkg::SLOTS_DEF];
      int unsigned          entry_count;
      int unsigned          error_count;
      kiht_pkg::result_type pending_results[$];

      function new();
         foreach (slot_table[i]) slot_table[i] = '0;
         entry_count = 0;
         error_count = 0;
      endfunction

      function int unsigned home_slot(logic [63:0] key);
         logic [63:0] product;
         product = key * kiht_pkg::GOLDEN_MUL;
         return product[63:32] & (kiht_pkg::SLOTS_DEF - 1);
      endfunction

      function void note_request(kiht_pkg::op_type op);
         kiht_pkg::result_type res;
         int unsigned          slot;
         int unsigned          free_slot;
         int unsigned          idx;
         int unsigned          visited;
         bit                   found;
         bit                   stopped;
         slot      = home_slot(op.key);
         free_slot = kiht_pkg::SLOTS_DEF;
         idx       = 0;
         found     = 1'b0;
         stopped   = 1'b0;
         for (visited = 0; visited < kiht_pkg::SLOTS_DEF && !stopped; visited++) begin
            if (slot_table[slot] == 0) begin
               free_slot = slot;
               stopped   = 1'b1;
            end else if (key_store[slot_table[slot] - 1] == op.key) begin
               idx     = slot_table[slot] - 1;
               found   = 1'b1;
               stopped = 1'b1;
            end else begin
               slot = (slot + 1) & (kiht_pkg::SLOTS_DEF - 1);
            end
         end
         res = '0;
         if (found) begin
            if (op.action == ACT_INTERN) flag_store[idx] = flag_store[idx] | op.new_flags;
            res.status      = kiht_pkg::ST_EXISTING;
            res.entry_index = idx[7:0];
            res.entry_flags = flag_store[idx];
         end else if (op.action == ACT_FIND) begin
            res.status = kiht_pkg::ST_NOT_FOUND;
         end else if (entry_count >= kiht_pkg::CAPACITY_DEF ||
                      free_slot >= kiht_pkg::SLOTS_DEF) begin
            res.status = kiht_pkg::ST_FULL;
         end else begin
            idx                   = entry_count;
            key_store[idx]        = op.key;
            flag_store[idx]       = op.new_flags;
            slot_table[free_slot] = 9'(idx + 1);
            entry_count           = idx + 1;
            res.status            = kiht_pkg::ST_ADDED;
            res.entry_index       = idx[7:0];
            res.entry_flags       = op.new_flags;
         end
         pending_results.push_back(res);
      endfunction

      function void check_result(kiht_pkg::result_type got);
         kiht_pkg::result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d index %0d flags %h",
                     $time, got.status, got.entry_index, got.entry_flags);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
         end
         if (got.entry_index !== want.entry_index) begin
            $display("%0t: entry_index mismatch: expected %0d, actual %0d",
                     $time, want.entry_index, got.entry_index);
            error_count++;
         end
         if (got.entry_flags !== want.entry_flags) begin
            $display("%0t: entry_flags mismatch: expected %h, actual %h",
                     $time, want.entry_flags, got.entry_flags);
            error_count++;
         end
      endfunction
   endclass

   intern_scoreboard sb = new();

   key_intern_hash_table_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result({rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8]});
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [63:0] key_homed_at(int unsigned slot, logic [63:0] start);
      logic [63:0] key;
      key = start;
      while (sb.home_slot(key) != slot) key++;
      return key;
   endfunction

   task automatic send_op(logic action, logic [63:0] key, logic [7:0] new_flags);
      kiht_pkg::op_type op;
      op.action    = action;
      op.key       = key;
      op.new_flags = new_flags;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {new_flags, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [63:0] top_a;
      logic [63:0] top_b;
      logic [63:0] top_c;
      logic [63:0] twin_a;
      logic [63:0] twin_b;
      top_a  = key_homed_at(kiht_pkg::SLOTS_DEF - 1, 64'd1);
      top_b  = key_homed_at(kiht_pkg::SLOTS_DEF - 1, top_a + 1);
      top_c  = key_homed_at(kiht_pkg::SLOTS_DEF - 1, top_b + 1);
      twin_a = key_homed_at(sb.home_slot(KEY_ALL_ONES), 64'd1);
      twin_b = key_homed_at(sb.home_slot(KEY_ALL_ONES), twin_a + 1);
      send_op(ACT_FIND,   64'd0,        8'h00);
      send_op(ACT_INTERN, 64'd0,        8'h00);
      send_op(ACT_INTERN, 64'd0,        8'hFF);
      send_op(ACT_FIND,   64'd0,        8'h00);
      send_op(ACT_INTERN, KEY_ALL_ONES, 8'hA5);
      send_op(ACT_FIND,   KEY_ALL_ONES, 8'hFF);
      // The last slot is filled so that the next probe wraps round to the first.
      send_op(ACT_INTERN, top_a,        8'h01);
      send_op(ACT_INTERN, top_b,        8'h80);
      send_op(ACT_FIND,   top_b,        8'h00);
      send_op(ACT_FIND,   top_a,        8'h00);
      send_op(ACT_FIND,   top_c,        8'h00);
      send_op(ACT_INTERN, twin_a,       8'h5A);
      send_op(ACT_FIND,   twin_a,       8'h00);
      send_op(ACT_INTERN, twin_a,       8'h0F);
      send_op(ACT_FIND,   twin_b,       8'h00);
      send_op(ACT_INTERN, KEY_ALL_ONES, 8'h00);
   endtask

   task automatic run_phase(int send_pct, int recv_pct);
      int          choice;
      logic [63:0] key;
      drain_results();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i == PHASE_ITEMS / 2) drain_results();
         choice = $urandom_range(99);
         key    = {$urandom, $urandom};
         if (choice >= 30 && choice < 85 && sb.entry_count > 0) begin
            key = sb.key_store[$urandom_range(sb.entry_count - 1)];
         end
         send_op((choice < 60) ? ACT_INTERN : ACT_FIND, key, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      send_idle_pct  = 29;
      recv_stall_pct = 58;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(29, 58);
      run_phase(58, 29);
      run_phase(0, 0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
